// ----- rtl/sepe_pkg.sv -----
// Package with payload types, register indexes and the arctangent table.
`default_nettype none
package sepe_pkg;

    localparam int ANGLE_BITS    = 24;
    localparam int ANGLE_SHIFT   = 32 - ANGLE_BITS;
    localparam int PRESCALE_BITS = 20;
    localparam int SQRT_STEPS    = 33;
    localparam int DIFF_W        = 33;
    localparam int DIST_W        = 33;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_Y = 2'd1;

    localparam logic [31:0] TURN_ZERO    = 32'h0000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_3QUART  = 32'hC000_0000;

    localparam logic EV_START = 1'b0;
    localparam logic EV_END   = 1'b1;

    typedef struct packed {
        logic signed [31:0] end_a_x;
        logic signed [31:0] end_a_y;
        logic signed [31:0] end_b_x;
        logic signed [31:0] end_b_y;
        logic [15:0]        segment_tag;
    } t_seg_in;

    typedef struct packed {
        logic signed [31:0]     point_x;
        logic signed [31:0]     point_y;
        logic [ANGLE_BITS-1:0]  polar_angle;
        logic [DIST_W-1:0]      radial_distance;
        logic                   event_kind;
        logic [15:0]            owner_tag;
        logic                   last_of_pair;
    } t_event_out;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sepe_polar.sv -----
// Pipelined polar conversion of one difference vector: CORDIC angle and rounded square root.
`default_nettype none
module sepe_polar #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [sepe_pkg::DIFF_W-1:0]   i_dx,
    input  wire logic signed [sepe_pkg::DIFF_W-1:0]   i_dy,
    output logic [sepe_pkg::ANGLE_BITS-1:0]           o_angle,
    output logic [sepe_pkg::DIST_W-1:0]               o_dist
);
    localparam int NIT = (CORDIC_STEPS > sepe_pkg::SQRT_STEPS) ? CORDIC_STEPS
                                                               : sepe_pkg::SQRT_STEPS;
    localparam int XW  = 56;
    localparam int RW  = 2 * sepe_pkg::SQRT_STEPS;
    localparam int MW  = sepe_pkg::SQRT_STEPS + 2;

    // First stage: squares, CORDIC start vector and axis cases.
    logic signed [sepe_pkg::DIFF_W:0] w_dx1, w_dy1, w_nx, w_ny;
    logic [sepe_pkg::DIFF_W-1:0]      w_ax, w_ay;
    logic                             w_spc;
    logic [31:0]                      w_sacc;

    always_comb begin
        w_dx1 = (sepe_pkg::DIFF_W+1)'(i_dx);
        w_dy1 = (sepe_pkg::DIFF_W+1)'(i_dy);
        w_ax  = i_dx[sepe_pkg::DIFF_W-1] ? sepe_pkg::DIFF_W'(-w_dx1) : i_dx;
        w_ay  = i_dy[sepe_pkg::DIFF_W-1] ? sepe_pkg::DIFF_W'(-w_dy1) : i_dy;
        w_nx  = i_dx[sepe_pkg::DIFF_W-1] ? -w_dx1 : w_dx1;
        w_ny  = i_dx[sepe_pkg::DIFF_W-1] ? -w_dy1 : w_dy1;
        w_spc  = (i_dx == '0) || (i_dy == '0);
        if (i_dy == '0) begin
            w_sacc = (i_dx[sepe_pkg::DIFF_W-1]) ? sepe_pkg::TURN_HALF : sepe_pkg::TURN_ZERO;
        end else begin
            w_sacc = (i_dy > 0) ? sepe_pkg::TURN_QUARTER : sepe_pkg::TURN_3QUART;
        end
    end

    logic [RW-2:0]         r_sqx, r_sqy;
    logic signed [XW-1:0]  r_ax0, r_ay0;
    logic [31:0]           r_aacc;
    logic                  r_aspc;
    logic [31:0]           r_asacc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx   <= (RW-1)'(w_ax * w_ax);
            r_sqy   <= (RW-1)'(w_ay * w_ay);
            r_ax0   <= XW'(w_nx) <<< sepe_pkg::PRESCALE_BITS;
            r_ay0   <= XW'(w_ny) <<< sepe_pkg::PRESCALE_BITS;
            r_aacc  <= i_dx[sepe_pkg::DIFF_W-1] ? sepe_pkg::TURN_HALF : sepe_pkg::TURN_ZERO;
            r_aspc  <= w_spc;
            r_asacc <= w_sacc;
        end
    end

    // Iteration chain; entry 0 holds the summed norm and the start vector.
    logic signed [XW-1:0] r_x [NIT+1];
    logic signed [XW-1:0] r_y [NIT+1];
    logic [31:0]          r_acc [NIT+1];
    logic                 r_spc [NIT+1];
    logic [31:0]          r_sacc [NIT+1];
    logic [RW-1:0]        r_rad [NIT+1];
    logic [MW-1:0]        r_rem [NIT+1];
    logic [sepe_pkg::SQRT_STEPS-1:0] r_root [NIT+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= r_ax0;
            r_y[0]    <= r_ay0;
            r_acc[0]  <= r_aacc;
            r_spc[0]  <= r_aspc;
            r_sacc[0] <= r_asacc;
            r_rad[0]  <= RW'(r_sqx) + RW'(r_sqy);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < NIT; k++) begin : g_step
        logic signed [XW-1:0] n_x, n_y;
        logic [31:0]          n_acc;
        logic [MW-1:0]        n_rem;
        logic [sepe_pkg::SQRT_STEPS-1:0] n_root;
        logic [MW+1:0]        w_shr, w_trial;

        always_comb begin
            n_x   = r_x[k];
            n_y   = r_y[k];
            n_acc = r_acc[k];
            if (k < CORDIC_STEPS) begin
                if (r_y[k] > 0) begin
                    n_x   = r_x[k] + (r_y[k] >>> k);
                    n_y   = r_y[k] - (r_x[k] >>> k);
                    n_acc = r_acc[k] + sepe_pkg::atan_entry(k);
                end else begin
                    n_x   = r_x[k] - (r_y[k] >>> k);
                    n_y   = r_y[k] + (r_x[k] >>> k);
                    n_acc = r_acc[k] - sepe_pkg::atan_entry(k);
                end
            end
            w_shr   = {r_rem[k], r_rad[k][RW-1:RW-2]};
            w_trial = (MW+2)'({r_root[k], 2'b01});
            n_rem   = r_rem[k];
            n_root  = r_root[k];
            if (k < sepe_pkg::SQRT_STEPS) begin
                if (w_shr >= w_trial) begin
                    n_rem  = MW'(w_shr - w_trial);
                    n_root = {r_root[k][sepe_pkg::SQRT_STEPS-2:0], 1'b1};
                end else begin
                    n_rem  = MW'(w_shr);
                    n_root = {r_root[k][sepe_pkg::SQRT_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_acc[k+1]  <= n_acc;
                r_spc[k+1]  <= r_spc[k];
                r_sacc[k+1] <= r_sacc[k];
                r_rad[k+1]  <= {r_rad[k][RW-3:0], 2'b00};
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
            end
        end
    end

    // Final rounding; the dropped carry wraps a full turn to zero.
    logic [31:0] w_facc;
    logic [32:0] w_rsum;

    always_comb begin
        w_facc = r_spc[NIT] ? r_sacc[NIT] : r_acc[NIT];
        w_rsum = {1'b0, w_facc} + (33'd1 << (sepe_pkg::ANGLE_SHIFT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= w_rsum[31:sepe_pkg::ANGLE_SHIFT];
            o_dist  <= r_root[NIT] +
                       sepe_pkg::DIST_W'(r_rem[NIT] > MW'(r_root[NIT]));
        end
    end

endmodule
`default_nettype wire

// ----- rtl/segment_endpoint_polar_events.sv -----
// Top level: converts segment endpoints to polar events around a source point.
//
// Input channel (i_valid, o_ready, i_data) takes one segment per beat: two
// endpoints and a tag. Output channel (o_valid, i_ready, o_data) gives two
// event beats per segment, the endpoint with the smaller angle first as start,
// the other second as end with last_of_pair set; on equal angles B is first.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data)
// writes source_x at index 0 and source_y at index 1; it is always ready and
// other indexes are dropped.
// The depth from input beat to first output beat does not grow with
// CORDIC_STEPS while it is at most 33, the square root step count.
// The depth is set by the bit-per-stage square root and the CORDIC stages.
// A new segment can enter every cycle while the output buffer is empty;
// otherwise only as the single output channel hands out the second beat.
// When the receiver stalls, the output buffer holds its pair and the whole
// pipeline freezes with it, so nothing is lost or repeated.
// Reset clears the sources to zero and all valid bits, emptying the pipeline.
`default_nettype none
module segment_endpoint_polar_events #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire sepe_pkg::t_seg_in                  i_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output sepe_pkg::t_event_out                    o_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [sepe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);
    localparam int NIT = (CORDIC_STEPS > sepe_pkg::SQRT_STEPS) ? CORDIC_STEPS
                                                               : sepe_pkg::SQRT_STEPS;
    localparam int LAT = NIT + 3;

    logic signed [31:0] r_src_x, r_src_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x <= '0;
            r_src_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sepe_pkg::CFG_SOURCE_X: r_src_x <= i_cfg_data;
                sepe_pkg::CFG_SOURCE_Y: r_src_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_ob_valid, r_ob_phase;
    logic w_en;

    assign w_en    = !r_ob_valid || (i_ready && r_ob_phase);
    assign o_ready = w_en;

    // Entry stage: differences to the source.
    logic                                r_s0_valid;
    sepe_pkg::t_seg_in                   r_s0;
    logic signed [sepe_pkg::DIFF_W-1:0]  r_dax, r_day, r_dbx, r_dby;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0  <= i_data;
            r_dax <= sepe_pkg::DIFF_W'(i_data.end_a_x) - sepe_pkg::DIFF_W'(r_src_x);
            r_day <= sepe_pkg::DIFF_W'(i_data.end_a_y) - sepe_pkg::DIFF_W'(r_src_y);
            r_dbx <= sepe_pkg::DIFF_W'(i_data.end_b_x) - sepe_pkg::DIFF_W'(r_src_x);
            r_dby <= sepe_pkg::DIFF_W'(i_data.end_b_y) - sepe_pkg::DIFF_W'(r_src_y);
        end
    end

    logic [sepe_pkg::ANGLE_BITS-1:0] w_ang_a, w_ang_b;
    logic [sepe_pkg::DIST_W-1:0]     w_dist_a, w_dist_b;

    sepe_polar #(.CORDIC_STEPS(CORDIC_STEPS)) u_polar_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_dax),
        .i_dy    (r_day),
        .o_angle (w_ang_a),
        .o_dist  (w_dist_a)
    );

    sepe_polar #(.CORDIC_STEPS(CORDIC_STEPS)) u_polar_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_dbx),
        .i_dy    (r_dby),
        .o_angle (w_ang_b),
        .o_dist  (w_dist_b)
    );

    // Payload and valid bits ride alongside the polar units.
    logic              r_pv [LAT];
    sepe_pkg::t_seg_in r_pl [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_pv[k] <= 1'b0;
        end else if (w_en) begin
            r_pv[0] <= r_s0_valid;
            for (int k = 1; k < LAT; k++) r_pv[k] <= r_pv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl[0] <= r_s0;
            for (int k = 1; k < LAT; k++) r_pl[k] <= r_pl[k-1];
        end
    end

    // Order the pair and hold both events in the output buffer.
    sepe_pkg::t_event_out w_ev_a, w_ev_b, r_ev0, r_ev1;
    logic                 w_a_first;

    always_comb begin
        w_a_first = w_ang_a < w_ang_b;
        w_ev_a.point_x         = r_pl[LAT-1].end_a_x;
        w_ev_a.point_y         = r_pl[LAT-1].end_a_y;
        w_ev_a.polar_angle     = w_ang_a;
        w_ev_a.radial_distance = w_dist_a;
        w_ev_a.owner_tag       = r_pl[LAT-1].segment_tag;
        w_ev_a.event_kind      = w_a_first ? sepe_pkg::EV_START : sepe_pkg::EV_END;
        w_ev_a.last_of_pair    = !w_a_first;
        w_ev_b.point_x         = r_pl[LAT-1].end_b_x;
        w_ev_b.point_y         = r_pl[LAT-1].end_b_y;
        w_ev_b.polar_angle     = w_ang_b;
        w_ev_b.radial_distance = w_dist_b;
        w_ev_b.owner_tag       = r_pl[LAT-1].segment_tag;
        w_ev_b.event_kind      = w_a_first ? sepe_pkg::EV_END : sepe_pkg::EV_START;
        w_ev_b.last_of_pair    = w_a_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_phase <= 1'b0;
        end else if (r_ob_valid && i_ready && !r_ob_phase) begin
            r_ob_phase <= 1'b1;
        end else if (w_en) begin
            r_ob_valid <= r_pv[LAT-1];
            r_ob_phase <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ev0 <= w_a_first ? w_ev_a : w_ev_b;
            r_ev1 <= w_a_first ? w_ev_b : w_ev_a;
        end
    end

    assign o_valid = r_ob_valid;
    assign o_data  = r_ob_phase ? r_ev1 : r_ev0;

endmodule
`default_nettype wire

// ----- rtl/sepe_checker.sv -----
// Port-level checker for the polar event block and its bind statement.
`default_nettype none
module sepe_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire sepe_pkg::t_event_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last_of_pair
        |=> o_valid && o_data.last_of_pair && o_data.owner_tag == $past(o_data.owner_tag))
        else $error("second event of a pair did not follow the first");

    a_kind_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.event_kind == o_data.last_of_pair)
        else $error("event kind does not match its place in the pair");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind segment_endpoint_polar_events sepe_checker u_sepe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
`default_nettype wire
